// ===== design/jbrs_pkg.sv =====
// ============================================================================
// jbrs_pkg - shared types and constants for the bracket region scanner
// Character codes, stack sizing, and the op and result records passed
// between the front end, the op queue and the stack back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package jbrs_pkg;

  // Sizing
  localparam int STACK_DEPTH = 64;
  localparam int LINE_BITS   = 20;
  localparam int CHAR_W      = 16;
  localparam int ID_W        = 20;
  localparam int OUT_LINE_W  = 20;
  localparam int DEPTH_OUT_W = 6;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);
  localparam int OPQ_DEPTH   = 2;
  localparam int OPQ_PW      = $clog2(OPQ_DEPTH);
  localparam int OPQ_CW      = $clog2(OPQ_DEPTH + 1);
  localparam int RESQ_DEPTH  = 2;
  localparam int RESQ_PW     = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR     = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_PSEP   = 16'h2029;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 16'h005D;

  // Stack operation issued by the front end
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic                 restart;
    op_kind_t             kind;
    logic                 is_array;
    logic [LINE_BITS-1:0] line;
  } op_t;

  typedef struct packed {
    logic                 is_array;
    logic [LINE_BITS-1:0] line;
  } stk_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]        region_id;
    logic                   is_array;
    logic [OUT_LINE_W-1:0]  opener_line;
    logic [OUT_LINE_W-1:0]  closer_line;
    logic [DEPTH_OUT_W-1:0] nest_depth;
  } res_t;

endpackage

`default_nettype wire

// ===== design/json_bracket_region_scanner_unit.sv =====
// ============================================================================
// json_bracket_region_scanner_unit - JSON bracket region scanner, top level
// Takes one UTF-16 code unit per transfer and reports multi-line brace and
// bracket regions.
// ============================================================================
// The unit accepts one character per clock while full is low. A region
// caused by a character can be popped once it is classified into the op
// queue and the stack back end has executed the op into the two-entry
// result queue. Both sides keep a one-per-clock rate; the figure is set by
// the back end, which performs one push or pop per clock while the result queue
// is not full, on a 64-entry stack memory with a write and a read port whose
// top entry sits in a register. The stack needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module json_bracket_region_scanner_unit
  import jbrs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [CHAR_W-1:0]      in_char_code,
  input  wire logic                   in_doc_start,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [ID_W-1:0]             out_region_id,
  output logic                        out_is_array,
  output logic [OUT_LINE_W-1:0]       out_opener_line,
  output logic [OUT_LINE_W-1:0]       out_closer_line,
  output logic [DEPTH_OUT_W-1:0]      out_nest_depth
);

  logic take;
  logic op_wr, op_rd, op_empty;
  op_t  op_in, op_out;
  res_t res;

  assign take = in_push && !in_full;

  // Classify characters
  jbrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_char_code),
    .doc_start (in_doc_start),
    .op_wr     (op_wr),
    .op        (op_in)
  );

  // Decouple classifier from stack
  jbrs_op_queue u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (op_wr),
    .wdata (op_in),
    .full  (in_full),
    .rd    (op_rd),
    .rdata (op_out),
    .empty (op_empty)
  );

  // Execute stack ops and emit regions
  jbrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (op_empty),
    .op        (op_out),
    .op_rd     (op_rd),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_region_id   = res.region_id;
  assign out_is_array    = res.is_array;
  assign out_opener_line = res.opener_line;
  assign out_closer_line = res.closer_line;
  assign out_nest_depth  = res.nest_depth;

endmodule

`default_nettype wire

// ===== design/jbrs_front.sv =====
// ============================================================================
// jbrs_front - character classifier
// Tracks lines, quoted strings and escapes, and turns each bracket into a
// push or pop op for the stack back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module jbrs_front
  import jbrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              doc_start,
  output logic                   op_wr,
  output op_t                    op
);

  logic                 str_r, str_nxt;
  logic                 esc_r, esc_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 str_b, esc_b;
  logic [LINE_BITS-1:0] line_b;
  op_kind_t             kind;
  logic                 sq;

  // Classify the character against the state left after an optional restart
  always_comb begin
    str_b    = doc_start ? 1'b0 : str_r;
    esc_b    = doc_start ? 1'b0 : esc_r;
    line_b   = doc_start ? '0 : line_r;
    str_nxt  = str_b;
    esc_nxt  = esc_b;
    line_nxt = line_b;
    kind     = OP_NONE;
    sq       = 1'b0;
    if (esc_b) begin
      esc_nxt = 1'b0;
    end else if (char_code == CH_LF || char_code == CH_PSEP) begin
      if (line_b != '1) begin
        line_nxt = line_b + LINE_BITS'(1);
      end
    end else if (char_code == CH_CR) begin
      // carriage return changes nothing
    end else if (str_b) begin
      if (char_code == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (char_code == CH_QUOTE) begin
        str_nxt = 1'b0;
      end
    end else if (char_code == CH_QUOTE) begin
      str_nxt = 1'b1;
    end else if (char_code == CH_LBRACE || char_code == CH_LBRACK) begin
      kind = OP_PUSH;
      sq   = (char_code == CH_LBRACK);
    end else if (char_code == CH_RBRACE || char_code == CH_RBRACK) begin
      kind = OP_POP;
      sq   = (char_code == CH_RBRACK);
    end
  end

  // Issue an op only when the stack side has something to do
  assign op_wr       = take && (doc_start || kind != OP_NONE);
  assign op.restart  = doc_start;
  assign op.kind     = kind;
  assign op.is_array = sq;
  assign op.line     = line_b;

  // Advance the scan state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_r  <= 1'b0;
      esc_r  <= 1'b0;
      line_r <= '0;
    end else if (take) begin
      str_r  <= str_nxt;
      esc_r  <= esc_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/jbrs_op_queue.sv =====
// ============================================================================
// jbrs_op_queue - short op queue between front end and back end
// Lets the classifier and the stack stall independently.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module jbrs_op_queue
  import jbrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire op_t  wdata,
  output logic      full,
  input  wire logic rd,
  output op_t       rdata,
  output logic      empty
);

  op_t               mem_r [OPQ_DEPTH];
  logic [OPQ_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OPQ_CW-1:0] cnt_r;

  assign full  = (cnt_r == OPQ_CW'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_r + OPQ_PW'(1);
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_r + OPQ_PW'(1);
      end
      cnt_r <= cnt_r + OPQ_CW'(wr) - OPQ_CW'(rd);
    end
  end

  // Hold op payloads
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr)
    else $error("op queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd)
    else $error("op queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (cnt_r == $past(cnt_r) + OPQ_CW'(1)))
    else $error("op queue count did not advance");

endmodule

`default_nettype wire

// ===== design/jbrs_back.sv =====
// ============================================================================
// jbrs_back - opener stack and region emitter
// Executes push and pop ops on the opener stack, emits regions for pairs
// that span lines, and buffers results in a two-entry output queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module jbrs_back
  import jbrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic op_empty,
  input  wire op_t  op,
  output logic      op_rd,
  input  wire logic out_pop,
  output logic      out_empty,
  output res_t      res
);

  stk_entry_t         stk_mem [STACK_DEPTH];
  stk_entry_t         top_r;
  stk_entry_t         wdata;
  logic [STK_CW-1:0]  stk_cnt_r, stk_cnt_nxt, cnt_base, cnt_dec;
  logic [ID_W-1:0]    rid_r, rid_nxt, rid_base;
  logic [STK_AW-1:0]  wa, ra;
  logic               we, emit, proceed;
  res_t               res_wdata;
  res_t               resq_r [RESQ_DEPTH];
  logic [RESQ_PW-1:0] rq_wr_ptr_r, rq_rd_ptr_r;
  logic [RESQ_CW-1:0] rq_cnt_r;
  logic               rq_full, rq_rd;

  assign rq_full   = (rq_cnt_r == RESQ_CW'(RESQ_DEPTH));
  assign out_empty = (rq_cnt_r == '0);
  assign rq_rd     = out_pop && !out_empty;
  assign proceed   = !op_empty && !rq_full;
  assign op_rd     = proceed;

  // Execute the op at the queue head against the cached top of stack
  always_comb begin
    cnt_base    = op.restart ? '0 : stk_cnt_r;
    rid_base    = op.restart ? '0 : rid_r;
    stk_cnt_nxt = stk_cnt_r;
    rid_nxt     = rid_r;
    we          = 1'b0;
    emit        = 1'b0;
    wa          = cnt_base[STK_AW-1:0];
    wdata.is_array = op.is_array;
    wdata.line     = op.line;
    if (proceed) begin
      stk_cnt_nxt = cnt_base;
      rid_nxt     = rid_base;
      unique case (op.kind)
        OP_PUSH: begin
          // a full stack is dropped before the new opener goes in
          if (cnt_base >= STK_CW'(STACK_DEPTH)) begin
            wa = '0;
          end
          we          = 1'b1;
          stk_cnt_nxt = STK_CW'(wa) + STK_CW'(1);
        end
        OP_POP: begin
          if (cnt_base == '0 || top_r.is_array != op.is_array) begin
            stk_cnt_nxt = '0;
          end else begin
            stk_cnt_nxt = cnt_base - STK_CW'(1);
            if (top_r.line != op.line) begin
              emit    = 1'b1;
              rid_nxt = rid_base + ID_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
    cnt_dec = stk_cnt_nxt - STK_CW'(1);
    ra      = cnt_dec[STK_AW-1:0];
  end

  assign res_wdata.region_id   = rid_base;
  assign res_wdata.is_array    = top_r.is_array;
  assign res_wdata.opener_line = OUT_LINE_W'(top_r.line);
  assign res_wdata.closer_line = OUT_LINE_W'(op.line);
  assign res_wdata.nest_depth  = DEPTH_OUT_W'(stk_cnt_nxt);

  // Stack memory; top of stack is re-read every cycle with write bypass
  always_ff @(posedge clk) begin
    if (we) begin
      stk_mem[wa] <= wdata;
    end
    top_r <= (we && wa == ra) ? wdata : stk_mem[ra];
  end

  // Advance stack depth and region id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r <= '0;
      rid_r     <= '0;
    end else begin
      stk_cnt_r <= stk_cnt_nxt;
      rid_r     <= rid_nxt;
    end
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_ptr_r <= '0;
      rq_rd_ptr_r <= '0;
      rq_cnt_r    <= '0;
    end else begin
      if (emit) begin
        rq_wr_ptr_r <= (rq_wr_ptr_r == RESQ_PW'(RESQ_DEPTH - 1)) ?
                       '0 : rq_wr_ptr_r + RESQ_PW'(1);
      end
      if (rq_rd) begin
        rq_rd_ptr_r <= (rq_rd_ptr_r == RESQ_PW'(RESQ_DEPTH - 1)) ?
                       '0 : rq_rd_ptr_r + RESQ_PW'(1);
      end
      rq_cnt_r <= rq_cnt_r + RESQ_CW'(emit) - RESQ_CW'(rq_rd);
    end
  end

  // Hold result payloads
  always_ff @(posedge clk) begin
    if (emit) begin
      resq_r[rq_wr_ptr_r] <= res_wdata;
    end
  end

  assign res = resq_r[rq_rd_ptr_r];

  assert property (@(posedge clk) disable iff (!rst_n) stk_cnt_r <= STK_CW'(STACK_DEPTH))
    else $error("stack depth out of range");
  assert property (@(posedge clk) disable iff (!rst_n) emit |-> (op.kind == OP_POP && !rq_full))
    else $error("region emitted without a pop or into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (res_wdata.opener_line != res_wdata.closer_line))
    else $error("same-line pair emitted");
  assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && op.kind == OP_PUSH) |=> (stk_cnt_r != '0))
    else $error("push left stack empty");

endmodule

`default_nettype wire
